FILE: rtl/clock_ratio_search_core_defines.svh
// Assertion macros shared by the clock ratio search RTL
`ifndef CLOCK_RATIO_SEARCH_CORE_DEFINES_SVH
`define CLOCK_RATIO_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CRS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/crs_pkg.sv
// Shared types and constants of the clock ratio search core
package crs_pkg;

  localparam int REF_W               = 14;
  localparam int FACTOR_CFG_W        = 9;
  localparam int PIX_W               = 16;
  localparam int CFG_DATA_W          = 16;
  localparam int CFG_INDEX_W         = 2;
  localparam int FACTOR_LIMIT_DEFAULT = 256;

  localparam logic [REF_W-1:0]        RESET_REFERENCE  = REF_W'(5000);
  localparam logic [FACTOR_CFG_W-1:0] RESET_MAX_FACTOR = FACTOR_CFG_W'(256);

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_CLOCK = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MULT        = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIV         = CFG_INDEX_W'(2);

  typedef struct packed {
    logic start;
    logic calc_a;
    logic mul;
    logic cmp;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic cand_last;
  } dp_status_t;

endpackage

FILE: rtl/crs_cfg.sv
// Configuration registers of the clock ratio search core
module crs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [crs_pkg::REF_W-1:0]          reference_clock,
  output logic [crs_pkg::FACTOR_CFG_W-1:0]   max_mult,
  output logic [crs_pkg::FACTOR_CFG_W-1:0]   max_div
);

  logic [crs_pkg::REF_W-1:0]        reference_clock_r, reference_clock_nxt;
  logic [crs_pkg::FACTOR_CFG_W-1:0] max_mult_r, max_mult_nxt;
  logic [crs_pkg::FACTOR_CFG_W-1:0] max_div_r, max_div_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    reference_clock_nxt = reference_clock_r;
    max_mult_nxt        = max_mult_r;
    max_div_nxt         = max_div_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crs_pkg::REG_REFERENCE_CLOCK: reference_clock_nxt = cfg_data[crs_pkg::REF_W-1:0];
        crs_pkg::REG_MAX_MULT:        max_mult_nxt = cfg_data[crs_pkg::FACTOR_CFG_W-1:0];
        crs_pkg::REG_MAX_DIV:         max_div_nxt  = cfg_data[crs_pkg::FACTOR_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_clock_r <= crs_pkg::RESET_REFERENCE;
      max_mult_r        <= crs_pkg::RESET_MAX_FACTOR;
      max_div_r         <= crs_pkg::RESET_MAX_FACTOR;
    end else begin
      reference_clock_r <= reference_clock_nxt;
      max_mult_r        <= max_mult_nxt;
      max_div_r         <= max_div_nxt;
    end
  end

  assign reference_clock = reference_clock_r;
  assign max_mult        = max_mult_r;
  assign max_div         = max_div_r;

endmodule

FILE: rtl/crs_ctrl.sv
// Search sequencer and result handshake of the clock ratio search core
`include "clock_ratio_search_core_defines.svh"

module crs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output crs_pkg::ctrl_cmd_t  cmd,
  input  crs_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.start    = (state_r == ST_IDLE) && in_valid;
    cmd.calc_a   = (state_r == ST_SETUP) || (state_r == ST_CMP);
    cmd.mul      = (state_r == ST_MUL);
    cmd.cmp      = (state_r == ST_CMP);
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.empty ? ST_FINISH : ST_SETUP;
        end
      end
      ST_SETUP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CMP;
      ST_CMP:   state_nxt = status.cand_last ? ST_FINISH : ST_MUL;
      ST_FINISH: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CRS_ASSERT_NEXT(a_mul_then_cmp, state_r == ST_MUL, state_r == ST_CMP)
  `CRS_ASSERT_NEXT(a_start_leaves_idle, cmd.start, (state_r == ST_SETUP) || (state_r == ST_FINISH))
  `CRS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r && (state_r == ST_IDLE))

endmodule

FILE: rtl/crs_dp.sv
// Candidate scan, cross-multiplied error compare and best-pair registers
`include "clock_ratio_search_core_defines.svh"

module crs_dp #(
  parameter int FACTOR_LIMIT = crs_pkg::FACTOR_LIMIT_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  crs_pkg::ctrl_cmd_t                    cmd,
  output crs_pkg::dp_status_t                   status,
  input  logic [crs_pkg::PIX_W-1:0]             in_pixel_clock_10khz,
  input  logic [crs_pkg::REF_W-1:0]             reference_clock,
  input  logic [crs_pkg::FACTOR_CFG_W-1:0]      max_mult,
  input  logic [crs_pkg::FACTOR_CFG_W-1:0]      max_div,
  output logic [$clog2(FACTOR_LIMIT+1)-1:0]     out_best_mult,
  output logic [$clog2(FACTOR_LIMIT+1)-1:0]     out_best_div
);

  localparam int FW = $clog2(FACTOR_LIMIT + 1);
  localparam int AW = crs_pkg::PIX_W + FW;
  localparam int PW = AW + FW;

  logic [FW-1:0] lim_m, lim_d;
  logic          last_m, last_pair;
  logic [AW-1:0] ref_ext, pix_ext;

  logic [crs_pkg::PIX_W-1:0] p_r, p_nxt;
  logic [FW-1:0] m_r, m_nxt, d_r, d_nxt;
  logic [AW-1:0] rm_r, rm_nxt, dp_r, dp_nxt, a_r, a_nxt;
  logic [FW-1:0] bm_r, bm_nxt, bd_r, bd_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic [FW-1:0] cm_r, cm_nxt, cd_r, cd_nxt;
  logic [AW-1:0] ca_r, ca_nxt;
  logic          clast_r, clast_nxt;
  logic [PW-1:0] prod_new_r, prod_new_nxt, prod_cur_r, prod_cur_nxt;
  logic [FW-1:0] out_m_r, out_m_nxt, out_d_r, out_d_nxt;

  assign lim_m = (32'(max_mult) > 32'(FACTOR_LIMIT)) ? FW'(FACTOR_LIMIT) : FW'(max_mult);
  assign lim_d = (32'(max_div) > 32'(FACTOR_LIMIT)) ? FW'(FACTOR_LIMIT) : FW'(max_div);

  assign ref_ext   = AW'(reference_clock);
  assign pix_ext   = AW'(p_r);
  assign last_m    = (m_r == lim_m);
  assign last_pair = last_m && (d_r == lim_d);

  assign status.empty     = (lim_m < FW'(2)) || (lim_d == '0);
  assign status.cand_last = clast_r;

  always_comb begin
    p_nxt        = p_r;
    m_nxt        = m_r;
    d_nxt        = d_r;
    rm_nxt       = rm_r;
    dp_nxt       = dp_r;
    a_nxt        = a_r;
    bm_nxt       = bm_r;
    bd_nxt       = bd_r;
    b_nxt        = b_r;
    cm_nxt       = cm_r;
    cd_nxt       = cd_r;
    ca_nxt       = ca_r;
    clast_nxt    = clast_r;
    prod_new_nxt = prod_new_r;
    prod_cur_nxt = prod_cur_r;
    out_m_nxt    = out_m_r;
    out_d_nxt    = out_d_r;

    if (cmd.start) begin
      p_nxt  = in_pixel_clock_10khz;
      m_nxt  = FW'(2);
      d_nxt  = FW'(1);
      rm_nxt = ref_ext << 1;
      dp_nxt = AW'(in_pixel_clock_10khz);
      bm_nxt = FW'(1);
      bd_nxt = '0;
      b_nxt  = ref_ext;
    end

    if (cmd.calc_a) begin
      a_nxt = (rm_r >= dp_r) ? (rm_r - dp_r) : (dp_r - rm_r);
    end

    if (cmd.mul) begin
      prod_new_nxt = PW'(bd_r) * PW'(a_r);
      prod_cur_nxt = PW'(d_r) * PW'(b_r);
      cm_nxt       = m_r;
      cd_nxt       = d_r;
      ca_nxt       = a_r;
      clast_nxt    = last_pair;
      if (!last_pair) begin
        if (last_m) begin
          m_nxt  = FW'(2);
          rm_nxt = ref_ext << 1;
          d_nxt  = d_r + FW'(1);
          dp_nxt = dp_r + pix_ext;
        end else begin
          m_nxt  = m_r + FW'(1);
          rm_nxt = rm_r + ref_ext;
        end
      end
    end

    if (cmd.cmp && (prod_new_r < prod_cur_r)) begin
      bm_nxt = cm_r;
      bd_nxt = cd_r;
      b_nxt  = ca_r;
    end

    if (cmd.load_out) begin
      out_m_nxt = bm_r;
      out_d_nxt = bd_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    rm_r       <= rm_nxt;
    dp_r       <= dp_nxt;
    a_r        <= a_nxt;
    bm_r       <= bm_nxt;
    bd_r       <= bd_nxt;
    b_r        <= b_nxt;
    cm_r       <= cm_nxt;
    cd_r       <= cd_nxt;
    ca_r       <= ca_nxt;
    clast_r    <= clast_nxt;
    prod_new_r <= prod_new_nxt;
    prod_cur_r <= prod_cur_nxt;
    out_m_r    <= out_m_nxt;
    out_d_r    <= out_d_nxt;
  end

  assign out_best_mult = out_m_r;
  assign out_best_div  = out_d_r;

  `CRS_ASSERT_NOW(a_cand_in_range, cmd.mul, (m_r >= FW'(2)) && (m_r <= lim_m) && (d_r != '0) && (d_r <= lim_d))
  `CRS_ASSERT_NEXT(a_best_div_in_range, cmd.cmp, bd_r <= lim_d)

endmodule

FILE: rtl/clock_ratio_search_core.sv
// Top level of the clock ratio search core
// For each requested pixel clock P the core scans every divider d from 1 to
// max_div and every multiplier m from 2 to max_mult (both capped at
// FACTOR_LIMIT) and returns the pair m/d closest to P/reference_clock, the
// earliest pair winning ties. A multiply state and a compare state update the
// best pair for each candidate in turn; an empty scan returns 1/0.
// One item is searched at a time; the next item is taken while the previous
// result waits in the output register.
// Configuration writes are always ready and must only happen while idle.
module clock_ratio_search_core #(
  parameter int FACTOR_LIMIT = crs_pkg::FACTOR_LIMIT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [crs_pkg::PIX_W-1:0]            in_pixel_clock_10khz,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(FACTOR_LIMIT+1)-1:0]    out_best_mult,
  output logic [$clog2(FACTOR_LIMIT+1)-1:0]    out_best_div,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  crs_pkg::ctrl_cmd_t               cmd;
  crs_pkg::dp_status_t              status;
  logic [crs_pkg::REF_W-1:0]        reference_clock;
  logic [crs_pkg::FACTOR_CFG_W-1:0] max_mult;
  logic [crs_pkg::FACTOR_CFG_W-1:0] max_div;

  crs_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reference_clock (reference_clock),
    .max_mult        (max_mult),
    .max_div         (max_div)
  );

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  crs_dp #(
    .FACTOR_LIMIT (FACTOR_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_pixel_clock_10khz (in_pixel_clock_10khz),
    .reference_clock      (reference_clock),
    .max_mult             (max_mult),
    .max_div              (max_div),
    .out_best_mult        (out_best_mult),
    .out_best_div         (out_best_div)
  );

endmodule

FILE: bench/tb_clock_ratio_search_core.sv
// Self-checking testbench for the clock ratio search core
module tb_clock_ratio_search_core;

  localparam int FACTOR_LIMIT  = crs_pkg::FACTOR_LIMIT_DEFAULT;
  localparam int FW            = $clog2(FACTOR_LIMIT + 1);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 76;
  localparam logic [crs_pkg::CFG_INDEX_W-1:0] REG_UNUSED = crs_pkg::CFG_INDEX_W'(3);

  typedef struct packed {
    logic [FW-1:0] mult;
    logic [FW-1:0] divider;
  } ratio_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [crs_pkg::PIX_W-1:0]          in_pixel_clock_10khz;
  logic                               out_valid;
  logic                               out_stall;
  logic [FW-1:0]                      out_best_mult;
  logic [FW-1:0]                      out_best_div;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [crs_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [crs_pkg::CFG_DATA_W-1:0]     cfg_data;

  logic [crs_pkg::REF_W-1:0]          ref_clock_cfg;
  logic [crs_pkg::FACTOR_CFG_W-1:0]   mult_limit_cfg;
  logic [crs_pkg::FACTOR_CFG_W-1:0]   div_limit_cfg;

  ratio_t pending_ratios[$];
  int     mismatch_count;
  int     requests_sent;
  int     ratios_checked;
  int     reg_writes;
  bit     pace_on;
  bit     hold_req;

  clock_ratio_search_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pixel_clock_10khz (in_pixel_clock_10khz),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_best_mult        (out_best_mult),
    .out_best_div         (out_best_div),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int idle_len(input bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_factor(input logic [crs_pkg::FACTOR_CFG_W-1:0] v);
    return (v > FACTOR_LIMIT) ? FACTOR_LIMIT : int'(v);
  endfunction

  function automatic longint abs_gap(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic ratio_t closest_ratio(input logic [crs_pkg::PIX_W-1:0] pix);
    ratio_t best;
    longint r, p, bm, bd, target, err_cur, err_new;
    int     lim_m, lim_d;
    r     = longint'(ref_clock_cfg);
    p     = longint'(pix);
    lim_m = clamp_factor(mult_limit_cfg);
    lim_d = clamp_factor(div_limit_cfg);
    bm    = 1;
    bd    = 0;
    for (int d = 1; d <= lim_d; d++) begin
      for (int m = 2; m <= lim_m; m++) begin
        target  = longint'(d) * bd * p;
        err_cur = abs_gap(longint'(d) * r * bm, target);
        err_new = abs_gap(bd * r * longint'(m), target);
        if (err_new < err_cur) begin
          bm = m;
          bd = d;
        end
      end
    end
    best.mult    = bm[FW-1:0];
    best.divider = bd[FW-1:0];
    return best;
  endfunction

  // drive out_stall: random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall = 1'b0;
        repeat (idle_len(1'b0)) @(negedge clk);
        if (pace_on) begin
          out_stall = 1'b1;
          repeat (idle_len(1'b0)) @(negedge clk);
        end
      end
    end
  end

  // compare each accepted result with the oldest expected ratio
  initial begin
    ratio_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_ratios.size() == 0) begin
          $display("%0t: unexpected result mult %0d div %0d", $time, out_best_mult,
                   out_best_div);
          mismatch_count++;
        end else begin
          want = pending_ratios.pop_front();
          ratios_checked++;
          if (out_best_mult !== want.mult) begin
            $display("%0t: best_mult expected %0d actual %0d", $time, want.mult,
                     out_best_mult);
            mismatch_count++;
          end
          if (out_best_div !== want.divider) begin
            $display("%0t: best_div expected %0d actual %0d", $time, want.divider,
                     out_best_div);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic send_request(input logic [crs_pkg::PIX_W-1:0] pix);
    int gap;
    in_valid             = 1'b1;
    in_pixel_clock_10khz = pix;
    do @(posedge clk); while (in_stall);
    pending_ratios.push_back(closest_ratio(pix));
    requests_sent++;
    @(negedge clk);
    gap = pace_on ? idle_len(1'b1) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_ratios.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [crs_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [crs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crs_pkg::REG_REFERENCE_CLOCK: ref_clock_cfg = data[crs_pkg::REF_W-1:0];
      crs_pkg::REG_MAX_MULT:        mult_limit_cfg = data[crs_pkg::FACTOR_CFG_W-1:0];
      crs_pkg::REG_MAX_DIV:         div_limit_cfg = data[crs_pkg::FACTOR_CFG_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // write all three registers, sometimes with junk above the field width
  task automatic set_search(input int ref_clk, input int mult_lim, input int div_lim);
    logic [crs_pkg::CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? crs_pkg::CFG_DATA_W'($urandom) : '0;
    write_register(crs_pkg::REG_REFERENCE_CLOCK,
                   {junk[15:14], crs_pkg::REF_W'(ref_clk)});
    write_register(crs_pkg::REG_MAX_MULT, {junk[15:9], crs_pkg::FACTOR_CFG_W'(mult_lim)});
    write_register(crs_pkg::REG_MAX_DIV, {junk[15:9], crs_pkg::FACTOR_CFG_W'(div_lim)});
  endtask

  task automatic test_reset_defaults();
    send_request(16'd14850);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    set_search(5000, 16, 16);
    send_request(16'd0);
    send_request(16'hFFFF);
    send_request(16'h5555);
    wait_idle();
    write_register(crs_pkg::REG_REFERENCE_CLOCK, 16'hFFFF);
    send_request(16'hAAAA);
    wait_idle();
    write_register(crs_pkg::REG_REFERENCE_CLOCK, 16'd1);
    send_request(16'd1);
    wait_idle();
  endtask

  task automatic test_limit_saturation();
    set_search(2700, 511, 1);
    send_request(16'd40000);
    wait_idle();
    set_search(2700, 2, 511);
    send_request(16'd21);
    wait_idle();
    set_search(10000, 257, 2);
    send_request(16'd65535);
    wait_idle();
  endtask

  task automatic test_empty_search();
    set_search(5000, 0, 5);
    send_request(16'd7425);
    wait_idle();
    set_search(5000, 1, 5);
    send_request(16'd7425);
    wait_idle();
    set_search(5000, 10, 0);
    write_register(REG_UNUSED, 16'hFFFF);
    send_request(16'd7425);
    wait_idle();
  endtask

  task automatic test_zero_reference();
    set_search(0, 8, 8);
    send_request(16'd1234);
    send_request(16'd0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    pace_on = 1'b0;
    set_search(2700, 6, 5);
    hold_req = 1'b1;
    repeat (10) send_request(16'($urandom_range(1000, 20000)));
    wait_idle();
    pace_on = 1'b1;
  endtask

  task automatic test_random_items();
    int sent, phase_len, ref_clk, mult_lim, div_lim, r, m, d, pix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      ref_clk = (r < 70) ? $urandom_range(1, 16383) :
                (r < 80) ? $urandom_range(1, 20) :
                (r < 88) ? $urandom_range(16000, 16383) :
                (r < 94) ? 0 : 5000;
      r = $urandom_range(0, 99);
      mult_lim = (r < 80) ? $urandom_range(2, 16) :
                 (r < 88) ? $urandom_range(17, 40) :
                 (r < 94) ? $urandom_range(0, 1) : $urandom_range(250, 511);
      r = $urandom_range(0, 99);
      div_lim = (r < 80) ? $urandom_range(1, 16) :
                (r < 88) ? $urandom_range(17, 40) :
                (r < 94) ? 0 : $urandom_range(250, 511);
      if (mult_lim > 40) div_lim = $urandom_range(0, 2);
      if (div_lim > 40) mult_lim = $urandom_range(0, 3);
      set_search(ref_clk, mult_lim, div_lim);
      pace_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(8, 16);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 1) == 1 && mult_lim >= 2 && div_lim >= 1) begin
          m   = $urandom_range(2, clamp_factor(mult_limit_cfg));
          d   = $urandom_range(1, clamp_factor(div_limit_cfg));
          pix = ref_clk * m / d + $urandom_range(0, 6) - 3;
          if (pix < 0) pix = 0;
          if (pix > 65535) pix = 65535;
        end else begin
          pix = $urandom_range(0, 65535);
        end
        send_request(16'(pix));
        sent++;
      end
      wait_idle();
    end
    pace_on = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_pixel_clock_10khz = '0;
    cfg_valid            = 1'b0;
    cfg_index            = crs_pkg::REG_REFERENCE_CLOCK;
    cfg_data             = '0;
    ref_clock_cfg        = crs_pkg::RESET_REFERENCE;
    mult_limit_cfg       = crs_pkg::RESET_MAX_FACTOR;
    div_limit_cfg        = crs_pkg::RESET_MAX_FACTOR;
    mismatch_count       = 0;
    requests_sent        = 0;
    ratios_checked       = 0;
    reg_writes           = 0;
    pace_on              = 1'b1;
    hold_req             = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_limit_saturation();
    test_empty_search();
    test_zero_reference();
    test_output_backpressure();
    test_random_items();

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Searched %0d pixel clock requests and checked %0d ratio results", requests_sent,
             ratios_checked);
    $display("over %0d register writes: full range, saturated, empty and zero reference",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_cfg.sv
rtl/crs_ctrl.sv
rtl/crs_dp.sv
rtl/clock_ratio_search_core.sv
bench/tb_clock_ratio_search_core.sv
